FILE: src/graph_edge_contour_length_assert.svh
// Assertion macros used by the graph edge contour length datapath.
`ifndef GRAPH_EDGE_CONTOUR_LENGTH_ASSERT_SVH
`define GRAPH_EDGE_CONTOUR_LENGTH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GECL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GECL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/gecl_pkg.sv
// Shared types, codes and defaults of the graph edge contour length block.
package gecl_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int LENGTH_BITS_DEF = 48;

	localparam int OP_BITS   = 2;
	localparam int CFG_W     = 8;
	localparam int NUM_AXES  = 3;
	localparam int AXIS_W    = 2;
	localparam int SQ_CNT_W  = 3;

	localparam logic [CFG_W-1:0]    LIMIT_RESET = 8'd3;
	localparam logic [SQ_CNT_W-1:0] SQ_LAST     = 3'd4;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef enum logic [OP_BITS-1:0] {
		OP_SRC    = 2'd0,
		OP_TGT    = 2'd1,
		OP_POINT  = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SQ,
		ST_CHECK,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_ADD,
		ST_OUT
	} state_t;

	// What the current squared distance / root is for.
	typedef enum logic [2:0] {
		STEP_POINT,
		STEP_NOPTS,
		STEP_DIR_A,
		STEP_DIR_B,
		STEP_SWP_A,
		STEP_SWP_B,
		STEP_GAP_A,
		STEP_GAP_B
	} step_t;

	// Operand pair of a squared distance.
	typedef enum logic [2:0] {
		PAIR_ITEM_LAST,
		PAIR_TGT_SRC,
		PAIR_SRC_FIRST,
		PAIR_TGT_LAST,
		PAIR_SRC_LAST,
		PAIR_TGT_FIRST
	} pair_t;

	typedef struct packed {
		logic              capture;
		logic              set_src;
		logic              set_tgt;
		logic              set_first;
		logic              set_last;
		logic              sq_clr;
		logic              sq_dst;     // 0: gap A register, 1: gap B register
		logic              axis_vld;
		logic [AXIS_W-1:0] axis;
		pair_t             pair;
		logic              root_start;
		logic              root_src;   // 0: gap A, 1: gap B
		logic              add;
		logic              set_disc;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic have_points;
		logic ok_a;
		logic ok_b;
		logic root_done;
		logic out_free;
	} sts_t;

endpackage

FILE: src/gecl_sqrt.sv
// Bit-serial restoring integer square root, one result bit per cycle.
module gecl_sqrt #(
	parameter int RAD_W = 66
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_W-1:0]     radicand,
	output logic                 busy,
	output logic                 done,
	output logic [RAD_W/2-1:0]   root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {r_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q <= rem_sh - trial;
				r_q   <= {r_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q   <= {r_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = r_q;

endmodule

FILE: src/gecl_dp.sv
// Datapath: positions, squared distances, root unit, accumulator, output register.
`include "graph_edge_contour_length_assert.svh"

module gecl_dp #(
	parameter int COORD_BITS  = gecl_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS   = gecl_pkg::FRAC_BITS_DEF,
	parameter int LENGTH_BITS = gecl_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gecl_pkg::cmd_t                cmd,
	output gecl_pkg::sts_t                sts,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gecl_pkg::CFG_W-1:0]    cfg_data,
	input  logic [gecl_pkg::OP_BITS-1:0]  in_op,
	input  logic signed [COORD_BITS-1:0]  in_x,
	input  logic signed [COORD_BITS-1:0]  in_y,
	input  logic signed [COORD_BITS-1:0]  in_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [LENGTH_BITS-1:0]        out_len,
	output logic                          out_disc,
	output logic                          out_sat
);

	import gecl_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int LB     = LENGTH_BITS;
	localparam int SQ_W   = 2 * CB + 2;
	localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int CMP_W  = (ROOT_W > LB) ? ROOT_W : LB;
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

	typedef logic signed [NUM_AXES-1:0][CB-1:0] pos_t;

	pos_t              item_q, src_q, tgt_q, first_q, last_q;
	op_t               op_q;
	logic [CFG_W-1:0]  limit_q;
	logic              have_q;
	logic [LB-1:0]     acc_q;
	logic              sat_q;
	logic              disc_q;
	logic [SQ_W-1:0]   sq_a_q, sq_b_q;
	logic [CB-1:0]     mag_s1;
	logic              vld_s1;
	logic [2*CB-1:0]   prod_s2;
	logic              vld_s2;
	logic [LB-1:0]     dist_q;
	logic              dist_sat_q;
	logic              out_valid_q;
	logic [LB-1:0]     out_len_q;
	logic              out_disc_q, out_sat_q;

	pos_t                 pos_a, pos_b;
	logic signed [CB-1:0] crd_a, crd_b;
	logic signed [CB:0]   diff;
	logic [CB-1:0]        mag;
	logic                 root_busy, root_done;
	logic [ROOT_W-1:0]    root;
	logic [RAD_W-1:0]     root_in;
	logic [CMP_W-1:0]     root_ext;
	logic [LB:0]          sum;
	logic                 out_free;

	// operand pair
	always_comb begin
		case (cmd.pair)
			PAIR_ITEM_LAST: begin pos_a = item_q; pos_b = last_q;  end
			PAIR_TGT_SRC:   begin pos_a = tgt_q;  pos_b = src_q;   end
			PAIR_SRC_FIRST: begin pos_a = src_q;  pos_b = first_q; end
			PAIR_TGT_LAST:  begin pos_a = tgt_q;  pos_b = last_q;  end
			PAIR_SRC_LAST:  begin pos_a = src_q;  pos_b = last_q;  end
			PAIR_TGT_FIRST: begin pos_a = tgt_q;  pos_b = first_q; end
			default:        begin pos_a = item_q; pos_b = last_q;  end
		endcase
	end

	always_comb begin
		case (cmd.axis)
			AXIS_X:  begin crd_a = pos_a[0]; crd_b = pos_b[0]; end
			AXIS_Y:  begin crd_a = pos_a[1]; crd_b = pos_b[1]; end
			AXIS_Z:  begin crd_a = pos_a[2]; crd_b = pos_b[2]; end
			default: begin crd_a = pos_a[0]; crd_b = pos_b[0]; end
		endcase
	end

	// |a-b| < 2^CB always fits CB bits
	assign diff = {crd_a[CB-1], crd_a} - {crd_b[CB-1], crd_b};
	assign mag  = diff[CB] ? CB'(-diff) : CB'(diff);

	assign root_in  = RAD_W'(cmd.root_src ? sq_b_q : sq_a_q) << (2 * FRAC_BITS);
	assign root_ext = CMP_W'(root);
	assign sum      = {1'b0, acc_q} + {1'b0, dist_q};
	assign out_free = !out_valid_q || out_ready;

	gecl_sqrt #(.RAD_W(RAD_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (root_in),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= '0;
			tgt_q       <= '0;
			limit_q     <= LIMIT_RESET;
			have_q      <= 1'b0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			disc_q      <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.set_src) begin
				src_q <= item_q;
			end
			if (cmd.set_tgt) begin
				tgt_q <= item_q;
			end
			if (cmd.set_first) begin
				have_q <= 1'b1;
			end
			vld_s1 <= cmd.axis_vld;
			vld_s2 <= vld_s1;
			if (cmd.set_disc) begin
				disc_q <= !(sts.ok_a && sts.ok_b);
			end
			if (cmd.add) begin
				if (sum[LB]) begin
					acc_q <= LEN_MAX;
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum[LB-1:0];
				end
				if (dist_sat_q) begin
					sat_q <= 1'b1;
				end
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				have_q      <= 1'b0;
				acc_q       <= '0;
				sat_q       <= 1'b0;
				disc_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(in_op);
			item_q <= {in_z, in_y, in_x};
		end
		if (cmd.set_first || cmd.set_last) begin
			last_q <= item_q;
		end
		if (cmd.set_first) begin
			first_q <= item_q;
		end
		mag_s1  <= mag;
		prod_s2 <= mag_s1 * mag_s1;
		if (cmd.sq_clr) begin
			if (cmd.sq_dst) begin
				sq_b_q <= '0;
			end else begin
				sq_a_q <= '0;
			end
		end else if (vld_s2) begin
			if (cmd.sq_dst) begin
				sq_b_q <= sq_b_q + SQ_W'(prod_s2);
			end else begin
				sq_a_q <= sq_a_q + SQ_W'(prod_s2);
			end
		end
		if (root_done) begin
			if (root_ext > CMP_W'(LEN_MAX)) begin
				dist_q     <= LEN_MAX;
				dist_sat_q <= 1'b1;
			end else begin
				dist_q     <= root_ext[LB-1:0];
				dist_sat_q <= 1'b0;
			end
		end
		if (cmd.emit) begin
			out_len_q  <= acc_q;
			out_disc_q <= disc_q;
			out_sat_q  <= sat_q;
		end
	end

	assign sts.op          = op_q;
	assign sts.have_points = have_q;
	assign sts.ok_a        = (sq_a_q <= SQ_W'(limit_q));
	assign sts.ok_b        = (sq_b_q <= SQ_W'(limit_q));
	assign sts.root_done   = root_done;
	assign sts.out_free    = out_free;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_len   = out_len_q;
	assign out_disc  = out_disc_q;
	assign out_sat   = out_sat_q;

	`GECL_ASSERT_NOW(a_root_idle_on_start, cmd.root_start, !root_busy, "root started while busy")
	`GECL_ASSERT_NOW(a_emit_slot_free, cmd.emit, out_free, "result overwrote pending output")
	`GECL_ASSERT_NOW(a_first_once, cmd.set_first, !have_q, "first point written twice in an edge")
	`GECL_ASSERT_NEXT(a_add_after_root, cmd.add, !vld_s2 && !root_busy, "add overlaps distance work")

endmodule

FILE: src/gecl_ctrl.sv
// Controller: sequences squared distances, roots and accumulation per request.
module gecl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  gecl_pkg::sts_t sts,
	output gecl_pkg::cmd_t cmd
);

	import gecl_pkg::*;

	state_t               state_q, state_n;
	step_t                step_q, step_n;
	logic [SQ_CNT_W-1:0]  cnt_q, cnt_n;

	// next state
	always_comb begin
		state_n = state_q;
		step_n  = step_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_n = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					OP_POINT: begin
						if (sts.have_points) begin
							step_n  = STEP_POINT;
							state_n = ST_SQ;
						end else begin
							state_n = ST_IDLE;
						end
					end
					OP_FINISH: begin
						step_n  = sts.have_points ? STEP_DIR_A : STEP_NOPTS;
						state_n = ST_SQ;
					end
					default: state_n = ST_IDLE;
				endcase
			end
			ST_SQ: begin
				if (cnt_q == SQ_LAST) begin
					case (step_q)
						STEP_DIR_A: step_n = STEP_DIR_B;
						STEP_SWP_A: step_n = STEP_SWP_B;
						default:    step_n = step_q;
					endcase
					case (step_q)
						STEP_DIR_A, STEP_SWP_A: state_n = ST_SQ;
						STEP_DIR_B, STEP_SWP_B: state_n = ST_CHECK;
						default:                state_n = ST_ROOT;
					endcase
				end
			end
			ST_CHECK: begin
				if (step_q == STEP_DIR_B && !(sts.ok_a && sts.ok_b)) begin
					step_n  = STEP_SWP_A;
					state_n = ST_SQ;
				end else begin
					step_n  = STEP_GAP_A;
					state_n = ST_ROOT;
				end
			end
			ST_ROOT: state_n = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (sts.root_done) begin
					state_n = ST_ADD;
				end
			end
			ST_ADD: begin
				case (step_q)
					STEP_POINT: state_n = ST_IDLE;
					STEP_GAP_A: begin
						step_n  = STEP_GAP_B;
						state_n = ST_ROOT;
					end
					default: state_n = ST_OUT;
				endcase
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign cnt_n = (state_q == ST_SQ && cnt_q != SQ_LAST) ? cnt_q + 1'b1 : '0;

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.pair = PAIR_ITEM_LAST;
		s_tready = 1'b0;
		case (step_q)
			STEP_NOPTS: cmd.pair = PAIR_TGT_SRC;
			STEP_DIR_A: cmd.pair = PAIR_SRC_FIRST;
			STEP_DIR_B: cmd.pair = PAIR_TGT_LAST;
			STEP_SWP_A: cmd.pair = PAIR_SRC_LAST;
			STEP_SWP_B: cmd.pair = PAIR_TGT_FIRST;
			default:    cmd.pair = PAIR_ITEM_LAST;
		endcase
		cmd.sq_dst   = (step_q == STEP_DIR_B) || (step_q == STEP_SWP_B);
		cmd.root_src = (step_q == STEP_GAP_B);
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_DISPATCH: begin
				cmd.set_src   = (sts.op == OP_SRC);
				cmd.set_tgt   = (sts.op == OP_TGT);
				cmd.set_first = (sts.op == OP_POINT) && !sts.have_points;
			end
			ST_SQ: begin
				cmd.sq_clr   = (cnt_q == '0);
				cmd.axis_vld = (cnt_q < SQ_CNT_W'(NUM_AXES));
				cmd.axis     = cnt_q[AXIS_W-1:0];
			end
			ST_CHECK:     cmd.set_disc = (step_q == STEP_SWP_B);
			ST_ROOT:      cmd.root_start = 1'b1;
			ST_ROOT_WAIT: cmd.root_start = 1'b0;
			ST_ADD: begin
				cmd.add      = 1'b1;
				cmd.set_last = (step_q == STEP_POINT);
			end
			ST_OUT:       cmd.emit = sts.out_free;
			default:      cmd.emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_POINT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

FILE: src/graph_edge_contour_length.sv
// Top level: 3D contour length of one graph edge over a stream of node and point requests.
// Node requests and the first point of an edge are stored only; each further point adds its
// distance from the last point, taken by the bit-serial square root.
// Finish: one root with no points; two roots with points, direct or with swapped ends; a
// waiting result sits in the output register. Throughput: one request in flight.
// arst_n clears nodes, sum and point flags and loads limit 3; first/last point stay unset.
module graph_edge_contour_length #(
	parameter int COORD_BITS  = gecl_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS   = gecl_pkg::FRAC_BITS_DEF,
	parameter int LENGTH_BITS = gecl_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration: connect_limit_sq
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gecl_pkg::CFG_W-1:0]            cfg_data,
	// request stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // x_coord, y_coord, z_coord
	input  logic [gecl_pkg::OP_BITS-1:0]          s_tuser,  // opcode
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((LENGTH_BITS+7)/8)*8-1:0]      m_tdata,  // contour_len
	output logic [1:0]                            m_tuser   // disconnected, saturated
);

	import gecl_pkg::*;

	localparam int CB        = COORD_BITS;
	localparam int OUT_TD_W  = ((LENGTH_BITS + 7) / 8) * 8;

	cmd_t                    cmd;
	sts_t                    sts;
	logic [LENGTH_BITS-1:0]  len;
	logic                    disc;
	logic                    sat;

	// Controller stores nodes and first points and walks other requests through squared distance
	// (3 axes through a 2-stage multiply pipe), root, saturating add and output hand-off.
	gecl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath owns all positions, the running sum and the output register, so a
	// finished result waits there while the next request is taken.
	gecl_dp #(
		.COORD_BITS  (COORD_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_x      (s_tdata[CB-1:0]),
		.in_y      (s_tdata[2*CB-1:CB]),
		.in_z      (s_tdata[3*CB-1:2*CB]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_len   (len),
		.out_disc  (disc),
		.out_sat   (sat)
	);

	// pad bits of tdata are zero
	assign m_tdata = OUT_TD_W'(len);
	assign m_tuser = {sat, disc};

endmodule
